// File: sv/fme_pkg.sv
// shared types and constants for the float to mantissa/exponent converter
package fme_pkg;

    localparam int RAW_W  = 64;
    localparam int MANT_W = 54;
    localparam int EXP_W  = 12;
    localparam int MAG_W  = 53;
    localparam int TZ_W   = 6;

    localparam int SP_FRAC_BITS = 23;
    localparam int SP_EXP_BITS  = 8;
    localparam int SP_BIAS      = 127;
    localparam int SP_CUT       = 13;
    localparam int DP_FRAC_BITS = 52;
    localparam int DP_EXP_BITS  = 11;
    localparam int DP_BIAS      = 1023;
    localparam int DP_CUT       = 42;

    localparam logic [SP_EXP_BITS-1:0] SP_EXP_ALL = '1;
    localparam logic [DP_EXP_BITS-1:0] DP_EXP_ALL = '1;

    localparam logic signed [EXP_W-1:0] SP_EXP_OFS = EXP_W'(SP_BIAS + SP_FRAC_BITS);
    localparam logic signed [EXP_W-1:0] DP_EXP_OFS = EXP_W'(DP_BIAS + DP_FRAC_BITS);
    localparam logic signed [EXP_W-1:0] SP_EXP_SUB = EXP_W'(1 - SP_BIAS - SP_FRAC_BITS);
    localparam logic signed [EXP_W-1:0] DP_EXP_SUB = EXP_W'(1 - DP_BIAS - DP_FRAC_BITS);

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_DOUBLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REDUCE     = 1'b1;

    typedef struct packed {
        logic                    invalid;
        logic                    neg;
        logic [MAG_W-1:0]        mag;
        logic signed [EXP_W-1:0] ex;
    } t_unpacked;

endpackage

// File: sv/fme_unpack.sv
// field extraction, hidden bit, bias removal and precision cut
module fme_unpack (
    input  logic [fme_pkg::RAW_W-1:0] i_raw,
    input  logic                      i_use_double,
    input  logic                      i_reduce,
    output fme_pkg::t_unpacked        o_unp
);
    import fme_pkg::*;

    logic [SP_EXP_BITS-1:0] sp_e;
    logic [DP_EXP_BITS-1:0] dp_e;
    logic [MAG_W-1:0]       mag;
    logic signed [EXP_W-1:0] ex;

    assign sp_e = i_raw[SP_FRAC_BITS +: SP_EXP_BITS];
    assign dp_e = i_raw[DP_FRAC_BITS +: DP_EXP_BITS];

    always_comb begin
        o_unp = '0;
        mag   = '0;
        ex    = '0;
        if (i_use_double) begin
            mag = {(dp_e != '0), i_raw[DP_FRAC_BITS-1:0]};
            ex  = (dp_e != '0) ? (EXP_W'(dp_e) - DP_EXP_OFS) : DP_EXP_SUB;
            if (i_reduce) begin
                mag = mag >> DP_CUT;
                ex  = ex + EXP_W'(DP_CUT);
            end
            o_unp.invalid = (dp_e == DP_EXP_ALL);
            o_unp.neg     = i_raw[RAW_W-1];
        end else begin
            mag = MAG_W'({(sp_e != '0), i_raw[SP_FRAC_BITS-1:0]});
            ex  = (sp_e != '0) ? (EXP_W'(sp_e) - SP_EXP_OFS) : SP_EXP_SUB;
            if (i_reduce) begin
                mag = mag >> SP_CUT;
                ex  = ex + EXP_W'(SP_CUT);
            end
            o_unp.invalid = (sp_e == SP_EXP_ALL);
            o_unp.neg     = i_raw[SP_FRAC_BITS + SP_EXP_BITS];
        end
        o_unp.mag = mag;
        o_unp.ex  = ex;
    end

endmodule

// File: sv/fme_norm.sv
// trailing zero strip, exponent adjust and sign apply
module fme_norm (
    input  fme_pkg::t_unpacked                i_unp,
    output logic signed [fme_pkg::MANT_W-1:0] o_mantissa,
    output logic signed [fme_pkg::EXP_W-1:0]  o_exponent,
    output logic                              o_invalid
);
    import fme_pkg::*;

    logic [TZ_W-1:0]   tz;
    logic [MAG_W-1:0]  shifted;
    logic [MANT_W-1:0] wide;

    always_comb begin
        tz = '0;
        for (int i = MAG_W - 1; i >= 0; i--) begin
            if (i_unp.mag[i]) begin
                tz = TZ_W'(i);
            end
        end
    end

    assign shifted = i_unp.mag >> tz;
    assign wide    = {1'b0, shifted};

    always_comb begin
        o_mantissa = '0;
        o_exponent = '0;
        o_invalid  = i_unp.invalid;
        if (!i_unp.invalid && i_unp.mag != '0) begin
            o_mantissa = i_unp.neg ? (MANT_W'(0) - wide) : wide;
            o_exponent = i_unp.ex + EXP_W'(tz);
        end
    end

endmodule

// File: sv/float_to_mantissa_exponent.sv
// top level: config registers, input register, conversion, result register
// throughput: one item per cycle unless the output stalls; input register feeds result register
// through one pass of unpack and trailing zero strip logic
// reset: synchronous active low, clears valid flags and config to binary32,
// full precision
module float_to_mantissa_exponent (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [fme_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [fme_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [fme_pkg::RAW_W-1:0]             i_raw_bits,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [fme_pkg::MANT_W-1:0]     o_mantissa,
    output logic signed [fme_pkg::EXP_W-1:0]      o_exponent,
    output logic                                  o_invalid
);
    import fme_pkg::*;

    logic                     r_use_double;
    logic                     r_reduce;
    logic                     r_in_valid;
    logic [RAW_W-1:0]         r_raw;
    logic                     r_out_valid;
    logic signed [MANT_W-1:0] r_mantissa;
    logic signed [EXP_W-1:0]  r_exponent;
    logic                     r_invalid;

    logic                     n_in_valid;
    logic                     n_out_valid;
    logic                     out_free;
    logic                     move;
    logic                     in_take;
    t_unpacked                unp;
    logic signed [MANT_W-1:0] n_mantissa;
    logic signed [EXP_W-1:0]  n_exponent;
    logic                     n_invalid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_double <= 1'b0;
            r_reduce     <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_USE_DOUBLE: r_use_double <= i_cfg_data[0];
                CFG_REDUCE:     r_reduce     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign move       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    assign n_in_valid  = in_take || (r_in_valid && !move);
    assign n_out_valid = move || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_raw <= i_raw_bits;
        end
        if (move) begin
            r_mantissa <= n_mantissa;
            r_exponent <= n_exponent;
            r_invalid  <= n_invalid;
        end
    end

    fme_unpack u_unpack (
        .i_raw        (r_raw),
        .i_use_double (r_use_double),
        .i_reduce     (r_reduce),
        .o_unp        (unp)
    );

    fme_norm u_norm (
        .i_unp      (unp),
        .o_mantissa (n_mantissa),
        .o_exponent (n_exponent),
        .o_invalid  (n_invalid)
    );

    assign o_out_valid = r_out_valid;
    assign o_mantissa  = r_mantissa;
    assign o_exponent  = r_exponent;
    assign o_invalid   = r_invalid;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_invalid) |-> (o_mantissa == '0 && o_exponent == '0))
        else $error("invalid item with nonzero payload");

    a_mant_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_mantissa != '0) |-> o_mantissa[0])
        else $error("mantissa not stripped of trailing zeros");

    a_zero_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_mantissa == '0) |-> (o_exponent == '0))
        else $error("zero mantissa with nonzero exponent");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while both stages are full and blocked");

endmodule
